// ===== hw/rtl/md5_stream_hash_core_defines.svh =====
// Assertion macros shared by the MD5 stream hash RTL.
`ifndef MD5_STREAM_HASH_CORE_DEFINES_SVH
`define MD5_STREAM_HASH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MD5SH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MD5SH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/md5sh_pkg.sv =====
// Types, constants and round tables of the MD5 stream hash core.
`timescale 1ns / 1ps

package md5sh_pkg;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP_RD,
    ST_COMP,
    ST_COMP_ADD,
    ST_OUT
  } md5sh_state_t;

  // Where the sequencer goes once a block compression completes.
  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_OUT
  } md5sh_ret_t;

  // Working words of the compression rounds.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5sh_work_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;
  localparam logic [5:0] LEN_OFFSET  = 6'd56;
  localparam logic [5:0] LAST_OFFSET = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [63:0] BYTE_BITS  = 64'd8;

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, four per group of sixteen rounds.
  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round.
  function automatic logic [3:0] md5sh_widx(input logic [5:0] round);
    logic [3:0] r;
    logic [3:0] idx;
    r = round[3:0];
    unique case (round[5:4])
      2'd0:    idx = r;
      2'd1:    idx = (r << 2) + r + 4'd1;
      2'd2:    idx = (r << 1) + r + 4'd5;
      default: idx = (r << 3) - r;
    endcase
    return idx;
  endfunction

  // Rotate amount of a round.
  function automatic logic [4:0] md5sh_rot(input logic [5:0] round);
    return ROT_TABLE[{round[5:4], round[1:0]}];
  endfunction

endpackage

// ===== hw/rtl/md5sh_in_if.sv =====
// Request channel carrying one message byte and its flags.
`timescale 1ns / 1ps

interface md5sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

// ===== hw/rtl/md5sh_out_if.sv =====
// Result channel carrying the four digest words.
`timescale 1ns / 1ps

interface md5sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source (output valid, digest_a, digest_b, digest_c, digest_d, input ready);
  modport sink   (input valid, digest_a, digest_b, digest_c, digest_d, output ready);
endinterface

// ===== hw/rtl/md5sh_round.sv =====
// One MD5 compression round: computes the new b word.
`timescale 1ns / 1ps

module md5sh_round (
  input  md5sh_pkg::md5sh_work_t work,
  input  logic [31:0]            w,
  input  logic [5:0]             round,
  output logic [31:0]            b_new
);
  import md5sh_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  rot;
  logic [5:0]  rot_rev;
  logic [31:0] rotated;

  // Boolean function of the current group of sixteen rounds.
  always_comb begin
    unique case (round[5:4])
      2'd0:    f = (work.b & work.c) | (~work.b & work.d);
      2'd1:    f = (work.d & work.b) | (~work.d & work.c);
      2'd2:    f = work.b ^ work.c ^ work.d;
      default: f = work.c ^ (work.b | ~work.d);
    endcase
  end

  // Sum, rotate left by a nonzero amount, and add b.
  assign sum     = work.a + f + K_TABLE[round] + w;
  assign rot     = md5sh_rot(round);
  assign rot_rev = 6'd32 - {1'b0, rot};
  assign rotated = (sum << rot) | (sum >> rot_rev);
  assign b_new   = work.b + rotated;

endmodule

// ===== hw/rtl/md5_stream_hash_core.sv =====
// Streaming MD5 digest core: byte intake, padding sequencer and round engine.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      data_byte, has_byte, end_of_message
//   out_ch   out  valid / ready      digest_a, digest_b, digest_c, digest_d
//
// A request without end_of_message is taken while idle. When its byte completes
// a 64-byte block, the sequencer primes the block memory read, runs 64 rounds on
// the single round unit (one memory word per round), then folds the result into
// the chaining words. An end_of_message request pushes one padding byte per cycle
// (9 to 72 bytes), pausing while a filled block is compressed.
// Reset is synchronous and active low; the block memory needs no clearing pass.
// A digest waits in the output register; only the next digest stalls on out_ch.
`timescale 1ns / 1ps
`include "md5_stream_hash_core_defines.svh"

module md5_stream_hash_core (
  input  logic               clk,
  input  logic               rst_n,
  md5sh_in_if.sink           in_ch,
  md5sh_out_if.source        out_ch
);
  import md5sh_pkg::*;

  md5sh_state_t state_r, state_nxt;
  md5sh_ret_t   ret_r, ret_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  bit_len_r, bit_len_nxt;
  logic [31:0]  chain_r [4];
  logic [31:0]  chain_nxt [4];
  logic [5:0]   round_r, round_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         pad_first_r, pad_first_nxt;
  logic         len_phase_r, len_phase_nxt;
  md5sh_work_t  work_r, work_nxt;
  logic [23:0]  asm_r;
  logic [31:0]  dig_r [4];

  logic [31:0]  blk_mem [16];
  logic [31:0]  rd_data_r;
  logic [3:0]   rd_addr;
  logic [5:0]   rd_round;

  logic         accept;
  logic         push_en;
  logic [7:0]   push_byte;
  logic         len_active;
  logic         out_load;
  logic [31:0]  b_new;

  assign accept     = in_ch.valid && in_ch.ready;
  assign len_active = !pad_first_r && (len_phase_r || (fill_r == LEN_OFFSET));
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // Round engine works on the word read for the current round.
  md5sh_round u_round (
    .work  (work_r),
    .w     (rd_data_r),
    .round (round_r),
    .b_new (b_new)
  );

  // Next state, byte pushes, padding and compression control.
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    fill_nxt      = fill_r;
    bit_len_nxt   = bit_len_r;
    chain_nxt     = chain_r;
    round_nxt     = round_r;
    out_valid_nxt = out_valid_r;
    pad_first_nxt = pad_first_r;
    len_phase_nxt = len_phase_r;
    work_nxt      = work_r;
    push_en       = 1'b0;
    push_byte     = in_ch.data_byte;
    in_ch.ready   = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.end_of_message) begin
            pad_first_nxt = 1'b1;
            len_phase_nxt = 1'b0;
          end
          ret_nxt = in_ch.end_of_message ? RET_PAD : RET_IDLE;
          if (in_ch.has_byte) begin
            push_en     = 1'b1;
            bit_len_nxt = bit_len_r + BYTE_BITS;
          end
          if (in_ch.has_byte && (fill_r == LAST_OFFSET)) begin
            state_nxt = ST_COMP_RD;
          end else if (in_ch.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (pad_first_r) begin
          push_byte = PAD_BYTE;
        end else if (len_active) begin
          push_byte = bit_len_r[{fill_r[2:0], 3'b000} +: 8];
        end else begin
          push_byte = ZERO_BYTE;
        end
        pad_first_nxt = 1'b0;
        len_phase_nxt = len_active;
        if (fill_r == LAST_OFFSET) begin
          state_nxt = ST_COMP_RD;
          ret_nxt   = len_active ? RET_OUT : RET_PAD;
        end
      end
      ST_COMP_RD: begin
        work_nxt  = '{a: chain_r[0], b: chain_r[1], c: chain_r[2], d: chain_r[3]};
        round_nxt = '0;
        state_nxt = ST_COMP;
      end
      ST_COMP: begin
        work_nxt  = '{a: work_r.d, b: b_new, c: work_r.b, d: work_r.c};
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_COMP_ADD;
        end
      end
      ST_COMP_ADD: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        unique case (ret_r)
          RET_PAD: state_nxt = ST_PAD;
          RET_OUT: state_nxt = ST_OUT;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          chain_nxt     = '{IV_A, IV_B, IV_C, IV_D};
          fill_nxt      = '0;
          bit_len_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (push_en) begin
      fill_nxt = fill_r + 6'd1;
    end
  end

  // Block memory read address: the word of the round about to run.
  assign rd_round = (state_r == ST_COMP_RD) ? 6'd0 : round_r + 6'd1;
  assign rd_addr  = md5sh_widx(rd_round);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= RET_IDLE;
      fill_r      <= '0;
      bit_len_r   <= '0;
      chain_r     <= '{IV_A, IV_B, IV_C, IV_D};
      round_r     <= '0;
      out_valid_r <= 1'b0;
      pad_first_r <= 1'b0;
      len_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      bit_len_r   <= bit_len_nxt;
      chain_r     <= chain_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
      pad_first_r <= pad_first_nxt;
      len_phase_r <= len_phase_nxt;
    end
  end

  // Working words, byte assembly and digest payload.
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (push_en) begin
      asm_r <= {push_byte, asm_r[23:8]};
    end
    if (out_load) begin
      dig_r <= chain_r;
    end
  end

  // Block memory: a word is written as its fourth byte arrives, read each cycle.
  always_ff @(posedge clk) begin
    if (push_en && (fill_r[1:0] == 2'b11)) begin
      blk_mem[fill_r[5:2]] <= {push_byte, asm_r};
    end
    rd_data_r <= blk_mem[rd_addr];
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.digest_a = dig_r[0];
  assign out_ch.digest_b = dig_r[1];
  assign out_ch.digest_c = dig_r[2];
  assign out_ch.digest_d = dig_r[3];

  // Checks on the sequencer.
  `MD5SH_ASSERT_NEXT(a_last_round_folds, (state_r == ST_COMP) && (round_r == LAST_ROUND), state_r == ST_COMP_ADD, "last round did not fold into the chaining words")
  `MD5SH_ASSERT_NEXT(a_end_starts_pad, accept && in_ch.end_of_message, (state_r == ST_PAD) || (state_r == ST_COMP_RD), "end of message did not start padding")
  `MD5SH_ASSERT_NEXT(a_final_fold_outputs, (state_r == ST_COMP_ADD) && (ret_r == RET_OUT), state_r == ST_OUT, "final block did not lead to the digest")
  `MD5SH_ASSERT_NOW(a_digest_from_out, $rose(out_valid_r), $past(state_r) == ST_OUT, "digest appeared outside the output step")
  `MD5SH_ASSERT_NEXT(a_restart_clears, out_load, (fill_r == 6'd0) && (bit_len_r == 64'd0), "message state not cleared after digest")

endmodule
